>>> hw/rtl/c3pf_pkg.sv
// Shared constants and types of the 3x3 convolution pixel filter.
`timescale 1ns / 1ps
`default_nettype none
package c3pf_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COEF_BITS  = 8;
    localparam int PIX_W      = 16;
    localparam int KROW_W     = 24;
    localparam int WID_W      = 12;
    localparam int HGT_W      = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 12;
    localparam int PEND_W     = 12;
    localparam int NORM_W     = 16;
    localparam int ADDR_W     = 5;
    localparam int ACC_W      = PIX_W + COEF_BITS + 4;
    localparam int QUO_W      = ACC_W - 1;
    localparam int DCNT_W     = $clog2(QUO_W);

    localparam logic signed [ACC_W-1:0] CLAMP_HI = ACC_W'(32000);
    localparam logic signed [ACC_W-1:0] CLAMP_LO = -ACC_W'(32000);

    typedef enum logic [2:0] {
        REG_KTOP   = 3'd0,
        REG_KMID   = 3'd1,
        REG_KBOT   = 3'd2,
        REG_MODE   = 3'd3,
        REG_NORM   = 3'd4,
        REG_WIDTH  = 3'd5,
        REG_HEIGHT = 3'd6
    } reg_idx_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_MAC   = 7'b0000100,
        S_SHIFT = 7'b0001000,
        S_FIN   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic             pre;
        logic             emit;
        logic             last;
        logic             skip_top;
        logic             skip_bot;
        logic             skip_left;
        logic             skip_right;
        logic             t_slot;
        logic             kvalid;
        logic [PIX_W-1:0] bot;
    } item_t;

endpackage
`default_nettype wire

>>> hw/rtl/conv3x3_pixel_filter_top.sv
// Top level of the 3x3 convolution pixel filter.
// Usage:
//   Pixels enter in raster order on in_valid/in_stall with func = 0; func = 1
//   is a flush transaction that drains one pending result after a frame.
//   Results leave on out_valid/out_stall (filtered, last_of_frame). The result
//   for a pixel leaves with the transaction frame_width+1 pixels later.
//   The user writes registers over the APB port only while the block is idle;
//   the block itself does not enforce this.
// Transactions: one at a time. A pixel or flush passes through the line store
//   read, the shared multiply-accumulate (one step per kernel tap), window
//   update and finish, and in blur mode the bit-serial divider, then into
//   the output register. A pixel that yields no result ends after the line
//   store read and window update.
// Reset: counters, window and output valid clear; registers take their defaults.
//   The line stores are not cleared.
// Stall: a finished result waits in the output register; the next
//   transaction is taken meanwhile and holds in its last step until the
//   register frees.
`timescale 1ns / 1ps
`default_nettype none
module conv3x3_pixel_filter_top
    import c3pf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ADDR_W-1:0]       paddr,
    input  wire logic [31:0]             pwdata,
    output logic      [31:0]             prdata,
    output logic                         pready,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    func,
    input  wire logic [PIX_W-1:0]        pixel,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [PIX_W-1:0]      filtered,
    output logic                         last_of_frame
);

    logic [KROW_W-1:0] ktop_reg, kmid_reg, kbot_reg;
    logic              mode_reg;
    logic [NORM_W-1:0] norm_reg;
    logic [WID_W-1:0]  fw_reg;
    logic [HGT_W-1:0]  fh_reg;

    logic [WID_W-1:0]  w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic [NORM_W-1:0] d_eff;

    state_t             state_reg, state_next;
    item_t              item_reg, item_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [PEND_W-1:0]  pend_reg, pend_next;
    logic [PIX_W-1:0]   win_reg [0:8];
    logic [1:0]         kr_reg, kr_next, kc_reg, kc_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [NORM_W-1:0]  rem_reg, rem_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic               neg_reg, neg_next;
    logic               ovalid_reg, ovalid_next;
    logic [PIX_W-1:0]   ores_reg;
    logic               olast_reg;

    logic [PIX_W-1:0]   mem0 [0:MAX_WIDTH-1];
    logic [PIX_W-1:0]   mem1 [0:MAX_WIDTH-1];
    logic [PIX_W-1:0]   rd0_reg, rd1_reg;
    logic               mem_rd, mem_wr;
    logic [COL_W-1:0]   mem_addr;

    logic               shift_en;
    logic [PIX_W-1:0]   nv_top, nv_mid;
    logic               load_out;
    logic [PIX_W-1:0]   res;

    // effective geometry
    always_comb
    begin
        if (fw_reg < WID_W'(3))
            w_eff = WID_W'(3);
        else if (fw_reg > WID_W'(MAX_WIDTH))
            w_eff = WID_W'(MAX_WIDTH);
        else
            w_eff = fw_reg;
        if (fh_reg < HGT_W'(3))
            h_eff = HGT_W'(3);
        else if (fh_reg > HGT_W'(MAX_HEIGHT))
            h_eff = HGT_W'(MAX_HEIGHT);
        else
            h_eff = fh_reg;
        d_eff = (norm_reg == '0) ? NORM_W'(1) : norm_reg;
    end

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ktop_reg <= '0;
            kmid_reg <= '0;
            kbot_reg <= '0;
            mode_reg <= 1'b0;
            norm_reg <= NORM_W'(1);
            fw_reg   <= WID_W'(848);
            fh_reg   <= HGT_W'(480);
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_KTOP:   ktop_reg <= pwdata[KROW_W-1:0];
                REG_KMID:   kmid_reg <= pwdata[KROW_W-1:0];
                REG_KBOT:   kbot_reg <= pwdata[KROW_W-1:0];
                REG_MODE:   mode_reg <= pwdata[0];
                REG_NORM:   norm_reg <= pwdata[NORM_W-1:0];
                REG_WIDTH:  fw_reg   <= pwdata[WID_W-1:0];
                REG_HEIGHT: fh_reg   <= pwdata[HGT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_KTOP:   prdata = 32'(ktop_reg);
            REG_KMID:   prdata = 32'(kmid_reg);
            REG_KBOT:   prdata = 32'(kbot_reg);
            REG_MODE:   prdata = 32'(mode_reg);
            REG_NORM:   prdata = 32'(norm_reg);
            REG_WIDTH:  prdata = 32'(fw_reg);
            REG_HEIGHT: prdata = 32'(fh_reg);
            default:    prdata = '0;
        endcase
    end

    // line stores
    always_ff @(posedge clk)
    begin
        if (mem_rd)
            rd0_reg <= mem0[mem_addr];
        if (mem_wr && !row_reg[0])
            mem0[mem_addr] <= pixel;
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd)
            rd1_reg <= mem1[mem_addr];
        if (mem_wr && row_reg[0])
            mem1[mem_addr] <= pixel;
    end

    // accept-time decode
    logic               take;
    logic [WID_W-1:0]   w1, pcl, kpos;
    logic [HGT_W-1:0]   cr;
    logic [WID_W-1:0]   cc;
    logic [WID_W:0]     col_inc;
    logic [HGT_W-1:0]   row_inc;

    // tap datapath
    logic [1:0]                      tcol;
    logic [3:0]                      win_idx;
    logic                            tap_en;
    logic [PIX_W-1:0]                tap_pix;
    logic [KROW_W-1:0]               krow;
    logic [COEF_BITS-1:0]            coef;
    logic signed [COEF_BITS+PIX_W:0] prod;
    logic [ACC_W-1:0]                mag;
    logic [NORM_W:0]                 rem_sh;
    logic signed [ACC_W-1:0]         q_s;

    always_comb
    begin
        tcol    = item_reg.pre ? kc_reg + 2'd1 : kc_reg;
        win_idx = {kr_reg, 1'b0} + {2'b00, kr_reg} + {2'b00, tcol};
        tap_en  = !(kr_reg == 2'd0 && item_reg.skip_top)
                && !(kr_reg == 2'd2 && item_reg.skip_bot)
                && !(kc_reg == 2'd0 && item_reg.skip_left)
                && !(kc_reg == 2'd2 && item_reg.skip_right)
                && !(item_reg.pre && kc_reg == 2'd2);
        tap_pix = (win_idx < 4'd9) ? win_reg[win_idx] : '0;
        case (kr_reg)
            2'd0:    krow = ktop_reg;
            2'd1:    krow = kmid_reg;
            default: krow = kbot_reg;
        endcase
        coef = krow[kc_reg*COEF_BITS +: COEF_BITS];
        prod = $signed(coef) * $signed({1'b0, tap_pix});

        mag    = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
        rem_sh = {rem_reg, quo_reg[QUO_W-1]};
        q_s    = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

        if (mode_reg)
            res = (q_s > CLAMP_HI) ? CLAMP_HI[PIX_W-1:0] : q_s[PIX_W-1:0];
        else if (acc_reg > CLAMP_HI)
            res = CLAMP_HI[PIX_W-1:0];
        else if (acc_reg < CLAMP_LO)
            res = CLAMP_LO[PIX_W-1:0];
        else
            res = acc_reg[PIX_W-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        pend_next   = pend_reg;
        kr_next     = kr_reg;
        kc_next     = kc_reg;
        acc_next    = acc_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        neg_next    = neg_reg;
        ovalid_next = ovalid_reg && out_stall;
        mem_rd      = 1'b0;
        mem_wr      = 1'b0;
        mem_addr    = col_reg;
        shift_en    = 1'b0;
        load_out    = 1'b0;
        take        = 1'b0;
        cr          = '0;
        cc          = '0;
        w1          = w_eff + WID_W'(1);
        pcl         = (pend_reg > w1) ? w1 : pend_reg;
        kpos        = w1 - pcl;
        col_inc     = {2'b00, col_reg} + (WID_W+1)'(1);
        row_inc     = {1'b0, row_reg} + HGT_W'(1);

        nv_top = item_reg.kvalid ? (item_reg.t_slot ? rd1_reg : rd0_reg) : '0;
        nv_mid = item_reg.kvalid ? (item_reg.t_slot ? rd0_reg : rd1_reg) : '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !func)
                begin
                    take             = 1'b1;
                    mem_rd           = 1'b1;
                    mem_wr           = 1'b1;
                    mem_addr         = col_reg;
                    pend_next        = '0;
                    item_next.pre    = (col_reg == '0);
                    item_next.emit   = (row_reg >= ROW_W'(2))
                                    || (row_reg == ROW_W'(1) && col_reg != '0);
                    item_next.t_slot = row_reg[0];
                    item_next.kvalid = 1'b1;
                    item_next.bot    = pixel;
                    cr = (col_reg == '0) ? {1'b0, row_reg} - HGT_W'(2)
                                         : {1'b0, row_reg} - HGT_W'(1);
                    cc = (col_reg == '0) ? w_eff - WID_W'(1)
                                         : {1'b0, col_reg} - WID_W'(1);
                    item_next.last   = (cr + HGT_W'(1) == h_eff)
                                    && (cc + WID_W'(1) == w_eff);
                    if (col_inc >= {1'b0, w_eff})
                    begin
                        col_next = '0;
                        if (row_inc >= h_eff)
                        begin
                            row_next  = '0;
                            pend_next = w1;
                        end
                        else
                            row_next = row_inc[ROW_W-1:0];
                    end
                    else
                        col_next = col_inc[COL_W-1:0];
                end
                else if (in_valid && func && pend_reg != '0)
                begin
                    take             = 1'b1;
                    mem_rd           = 1'b1;
                    mem_addr         = kpos[COL_W-1:0];
                    pend_next        = pcl - PEND_W'(1);
                    item_next.pre    = (kpos == '0);
                    item_next.emit   = 1'b1;
                    item_next.t_slot = h_eff[0];
                    item_next.kvalid = (kpos < w_eff);
                    item_next.bot    = '0;
                    cr = (kpos == '0) ? h_eff - HGT_W'(2) : h_eff - HGT_W'(1);
                    cc = (kpos == '0) ? w_eff - WID_W'(1) : kpos - WID_W'(1);
                    item_next.last   = (kpos != '0) && (kpos == w_eff);
                end
                item_next.skip_top   = (cr == '0);
                item_next.skip_bot   = (cr + HGT_W'(1) >= h_eff);
                item_next.skip_left  = (cc == '0);
                item_next.skip_right = (cc + WID_W'(1) >= w_eff);
                if (take)
                begin
                    state_next = S_FETCH;
                    kr_next    = '0;
                    kc_next    = '0;
                    acc_next   = '0;
                end
            end
            S_FETCH:
            begin
                if (!item_reg.pre)
                    shift_en = 1'b1;
                state_next = item_reg.emit ? S_MAC : S_IDLE;
                if (!item_reg.emit)
                    shift_en = 1'b1;
            end
            S_MAC:
            begin
                if (tap_en)
                    acc_next = acc_reg + ACC_W'(prod);
                if (kc_reg == 2'd2)
                begin
                    kc_next = '0;
                    kr_next = kr_reg + 2'd1;
                    if (kr_reg == 2'd2)
                        state_next = item_reg.pre ? S_SHIFT : S_FIN;
                end
                else
                    kc_next = kc_reg + 2'd1;
            end
            S_SHIFT:
            begin
                shift_en   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (mode_reg)
                begin
                    quo_next   = mag[QUO_W-1:0];
                    rem_next   = '0;
                    neg_next   = acc_reg[ACC_W-1];
                    dcnt_next  = DCNT_W'(QUO_W-1);
                    state_next = S_DIV;
                end
                else
                    state_next = S_OUT;
            end
            S_DIV:
            begin
                if (rem_sh >= {1'b0, d_eff})
                begin
                    rem_next = NORM_W'(rem_sh - {1'b0, d_eff});
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[NORM_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == '0)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    load_out    = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            col_reg    <= '0;
            row_reg    <= '0;
            pend_reg   <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
            if (shift_en)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= nv_top;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= nv_mid;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= item_reg.bot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        kr_reg   <= kr_next;
        kc_reg   <= kc_next;
        acc_reg  <= acc_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dcnt_reg <= dcnt_next;
        neg_reg  <= neg_next;
        if (load_out)
        begin
            ores_reg  <= res;
            olast_reg <= item_reg.last;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = ovalid_reg;
    assign filtered      = ores_reg;
    assign last_of_frame = olast_reg;

endmodule
`default_nettype wire

>>> hw/rtl/c3pf_checker.sv
// Port-level checks of the 3x3 convolution pixel filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module c3pf_checker
    import c3pf_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  pready,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [PIX_W-1:0]      filtered,
    input wire logic                  last_of_frame
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(filtered)
                                   && $stable(last_of_frame))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    a_known_handshake: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_stall, out_valid, pready}))
        else $error("handshake signal unknown");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a transaction in progress");

endmodule

bind conv3x3_pixel_filter_top c3pf_checker u_c3pf_checker (.*);
`default_nettype wire

>>> bench/tb_conv3x3_pixel_filter_top.sv
// Self-checking testbench of the 3x3 convolution pixel filter: directed and random frames.
`timescale 1ns / 1ps
module tb_conv3x3_pixel_filter_top;
    import c3pf_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   func = 1'b0;
    logic [PIX_W-1:0]       pixel = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic signed [PIX_W-1:0] filtered;
    logic                   last_of_frame;

    conv3x3_pixel_filter_top dut (.*);

    always #2 clk = ~clk;

    typedef struct {
        logic signed [PIX_W-1:0] value;
        logic                    last;
    } pix_result_t;

    pix_result_t pending_results[$];

    // predictor state
    logic [KROW_W-1:0] m_krow[3];
    logic              m_mode;
    logic [NORM_W-1:0] m_norm;
    logic [WID_W-1:0]  m_width;
    logic [HGT_W-1:0]  m_height;
    logic [PIX_W-1:0]  m_lines[2][MAX_WIDTH];
    logic [PIX_W-1:0]  m_win[9];
    int unsigned       m_col, m_row, m_pend;

    int  errors = 0;
    int  hold_off = 0;
    bit  no_idle = 1'b0;
    int  predicted_n = 0;

    function automatic int unsigned eff_w();
        eff_w = m_width < 3 ? 3 : (m_width > MAX_WIDTH ? MAX_WIDTH : m_width);
    endfunction

    function automatic int unsigned eff_h();
        eff_h = m_height < 3 ? 3 : (m_height > MAX_HEIGHT ? MAX_HEIGHT : m_height);
    endfunction

    function automatic logic [PIX_W-1:0] line_at(int unsigned slot, int unsigned c);
        line_at = c >= MAX_WIDTH ? '0 : m_lines[slot & 1][c];
    endfunction

    function automatic void win_shift(logic [PIX_W-1:0] t, logic [PIX_W-1:0] m,
                                      logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] nv[3];
        nv[0] = t; nv[1] = m; nv[2] = b;
        for (int r = 0; r < 3; r++)
        begin
            m_win[r*3]   = m_win[r*3+1];
            m_win[r*3+1] = m_win[r*3+2];
            m_win[r*3+2] = nv[r];
        end
    endfunction

    function automatic logic signed [PIX_W-1:0] conv_at(int unsigned wc, int unsigned cr,
                                                        int unsigned cc, int unsigned w,
                                                        int unsigned h);
        longint sum;
        longint q;
        int col;
        logic signed [COEF_BITS-1:0] k;
        sum = 0;
        for (int kr = 0; kr < 3; kr++)
        begin
            if ((kr == 0 && cr == 0) || (kr == 2 && cr + 1 >= h))
                continue;
            for (int kc = 0; kc < 3; kc++)
            begin
                if ((kc == 0 && cc == 0) || (kc == 2 && cc + 1 >= w))
                    continue;
                col = wc + kc - 1;
                if (col > 2)
                    continue;
                k = m_krow[kr][kc*COEF_BITS +: COEF_BITS];
                sum += longint'(k) * longint'(m_win[kr*3+col]);
            end
        end
        if (m_mode)
        begin
            q = sum / longint'(m_norm == 0 ? 1 : m_norm);
            if (q > 32000) q = 32000;
        end
        else
        begin
            q = sum;
            if (q > 32000) q = 32000;
            if (q < -32000) q = -32000;
        end
        conv_at = q[PIX_W-1:0];
    endfunction

    function automatic void predict_filter(logic f, logic [PIX_W-1:0] v);
        int unsigned w, h, k, r, c, cr, cc;
        logic [PIX_W-1:0] t, m;
        bit emit, got;
        pix_result_t res;
        w = eff_w(); h = eff_h();
        if (f)
        begin
            if (m_pend == 0)
                return;
            if (m_pend > w + 1) m_pend = w + 1;
            k = w + 1 - m_pend;
            if (k == 0)
            begin
                res.value = conv_at(2, h - 2, w - 1, w, h);
                res.last = 1'b0;
                win_shift(line_at(h, 0), line_at(h + 1, 0), '0);
            end
            else
            begin
                t = '0; m = '0;
                if (k < w)
                begin
                    t = line_at(h, k); m = line_at(h + 1, k);
                end
                win_shift(t, m, '0);
                res.value = conv_at(1, h - 1, k - 1, w, h);
                res.last = (k == w);
            end
            m_pend--;
            pending_results.push_back(res);
            predicted_n++;
            return;
        end
        r = m_row; c = m_col;
        t = line_at(r, c); m = line_at(r + 1, c);
        emit = (r >= 2) || (r == 1 && c >= 1);
        got = 1'b0; cr = 0; cc = 0;
        m_pend = 0;
        if (emit && c == 0)
        begin
            cr = r - 2; cc = w - 1;
            res.value = conv_at(2, cr, cc, w, h);
            got = 1'b1;
        end
        win_shift(t, m, v);
        if (c < MAX_WIDTH) m_lines[r & 1][c] = v;
        if (emit && c >= 1)
        begin
            cr = r - 1; cc = c - 1;
            res.value = conv_at(1, cr, cc, w, h);
            got = 1'b1;
        end
        if (got)
        begin
            res.last = (cr + 1 == h && cc + 1 == w);
            pending_results.push_back(res);
            predicted_n++;
        end
        c++;
        if (c >= w)
        begin
            c = 0; r++;
            if (r >= h)
            begin
                r = 0; m_pend = w + 1;
            end
        end
        m_col = c; m_row = r;
    endfunction

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_W'(4 * int'(idx)); pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_KTOP:   m_krow[0] = val[KROW_W-1:0];
            REG_KMID:   m_krow[1] = val[KROW_W-1:0];
            REG_KBOT:   m_krow[2] = val[KROW_W-1:0];
            REG_MODE:   m_mode = val[0];
            REG_NORM:   m_norm = val[NORM_W-1:0];
            REG_WIDTH:  m_width = val[WID_W-1:0];
            REG_HEIGHT: m_height = val[HGT_W-1:0];
            default: ;
        endcase
    endtask

    // offer one transaction; the predictor runs when it is accepted
    task automatic send_item(logic f, logic [PIX_W-1:0] v);
        while (!no_idle && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1; func <= f; pixel <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_filter(f, v);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
    endtask

    task automatic send_frame(int unsigned w, int unsigned h, bit ramp);
        for (int unsigned i = 0; i < w * h; i++)
            send_item(1'b0, ramp ? PIX_W'(i * 4099) : PIX_W'($urandom));
        for (int unsigned i = 0; i < w + 1; i++)
            send_item(1'b1, PIX_W'($urandom));
    endtask

    task automatic random_kernel();
        reg_write(REG_KTOP, $urandom);
        reg_write(REG_KMID, $urandom);
        reg_write(REG_KBOT, $urandom);
    endtask

    // receiver: random stalls, plus a forced hold-off
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(99) < 24);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result filtered=%0d last=%0b", $time,
                         filtered, last_of_frame);
                errors++;
            end
            else
            begin
                pix_result_t e;
                e = pending_results.pop_front();
                if (filtered !== e.value)
                begin
                    $display("%0t: filtered expected %0d got %0d", $time, e.value, filtered);
                    errors++;
                end
                if (last_of_frame !== e.last)
                begin
                    $display("%0t: last_of_frame expected %0b got %0b", $time, e.last,
                             last_of_frame);
                    errors++;
                end
            end
        end
    end

    typedef struct {
        logic              f;
        logic [PIX_W-1:0]  v;
        bit                check;
        logic signed [PIX_W-1:0] value;
        logic              last;
    } stim_row_t;

    initial
    begin
        #200000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        int unsigned items;
        m_krow[0] = '0; m_krow[1] = '0; m_krow[2] = '0;
        m_mode = 1'b0; m_norm = 1; m_width = 848; m_height = 480;
        foreach (m_win[i]) m_win[i] = '0;
        m_col = 0; m_row = 0; m_pend = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // flush with nothing pending is ignored
        send_item(1'b1, 16'hFFFF);
        wait_drained();

        // directed: 3x3 frame, centre-only kernel, gradient mode
        reg_write(REG_WIDTH, 2);        // below minimum, acts as 3
        reg_write(REG_HEIGHT, 1);
        reg_write(REG_KMID, 24'h000100);
        rows = '{
            '{1'b0, 16'd0,     1'b0, 0, 1'b0},
            '{1'b0, 16'd65535, 1'b0, 0, 1'b0},
            '{1'b0, 16'd32000, 1'b0, 0, 1'b0},
            '{1'b0, 16'd1,     1'b0, 0, 1'b0},
            '{1'b0, 16'd5,     1'b1, 0, 1'b0},
            '{1'b0, 16'd7,     1'b1, 32000, 1'b0},
            '{1'b0, 16'd32001, 1'b1, 32000, 1'b0},
            '{1'b0, 16'd8,     1'b1, 1, 1'b0},
            '{1'b0, 16'd9,     1'b1, 5, 1'b0},
            '{1'b1, 16'd0,     1'b1, 7, 1'b0},
            '{1'b1, 16'd0,     1'b1, 32000, 1'b0},
            '{1'b1, 16'd0,     1'b1, 8, 1'b0},
            '{1'b1, 16'd0,     1'b1, 9, 1'b1},
            '{1'b1, 16'd0,     1'b0, 0, 1'b0}
        };
        foreach (rows[i])
        begin
            int before_n;
            before_n = predicted_n;
            send_item(rows[i].f, rows[i].v);
            if (rows[i].check)
            begin
                if (predicted_n == before_n)
                begin
                    $display("%0t: directed row %0d expected %0d/%0b predicted none",
                             $time, i, rows[i].value, rows[i].last);
                    errors++;
                end
                else if (pending_results[$].value !== rows[i].value
                         || pending_results[$].last !== rows[i].last)
                begin
                    $display("%0t: directed row %0d expected %0d/%0b predicted %0d/%0b",
                             $time, i, rows[i].value, rows[i].last,
                             pending_results[$].value, pending_results[$].last);
                    errors++;
                end
            end
        end
        wait_drained();

        // negative extreme kernel, blur with zero divisor, then largest divisor
        reg_write(REG_KTOP, 24'h808080);
        reg_write(REG_KMID, 24'h7F807F);
        reg_write(REG_KBOT, 24'hFFFFFF);
        reg_write(REG_MODE, 1);
        reg_write(REG_NORM, 0);
        send_frame(3, 3, 1'b1);
        wait_drained();
        reg_write(REG_NORM, 65535);
        send_frame(3, 3, 1'b0);
        wait_drained();

        // pixel while results pend: new frame cuts the flush short
        reg_write(REG_MODE, 0);
        reg_write(REG_WIDTH, 4);
        reg_write(REG_HEIGHT, 3);
        for (int i = 0; i < 12; i++) send_item(1'b0, PIX_W'($urandom));
        send_item(1'b1, '0);
        send_frame(4, 3, 1'b0);
        wait_drained();

        // back-pressure: long receiver hold-off with no sender gaps
        no_idle = 1'b1;
        hold_off = 300;
        random_kernel();
        send_frame(4, 3, 1'b0);
        wait_drained();

        // random frames with random settings
        items = 0;
        while (items < 360)
        begin
            int unsigned w, h;
            no_idle = ($urandom_range(7) == 0);
            w = $urandom_range(3, 9); h = $urandom_range(3, 6);
            if ($urandom_range(15) == 0) w = $urandom_range(3, 40);
            random_kernel();
            reg_write(REG_MODE, $urandom_range(1));
            reg_write(REG_NORM, $urandom_range(3) == 0 ? $urandom_range(65535)
                                                       : $urandom_range(1, 40));
            reg_write(REG_WIDTH, w);
            reg_write(REG_HEIGHT, h);
            send_frame(w, h, 1'b0);
            if ($urandom_range(3) == 0)
                send_item(1'b1, '0);
            items += w * h + w + 1;
            wait_drained();
        end

        if (errors == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
